### design/crm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the counter rate monitor.
// No dependencies; imported by every module of the block.
package crm_pkg;

    localparam int VALUE_W    = 64;
    localparam int TIME_W     = 32;
    localparam int ROW_W      = 8;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = VALUE_W / DIGIT_W;
    localparam int TIME_DIGITS = TIME_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

    // counter modes
    localparam logic [1:0] MODE_GAUGE = 2'd0;
    localparam logic [1:0] MODE_C32   = 2'd1;
    localparam logic [1:0] MODE_C64   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_FIRST = 2'd0;
    localparam logic [1:0] STAT_EMIT  = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_ZERO  = 2'd3;

    typedef struct packed {
        logic [7:0]  row_index;
        logic [63:0] sample_value;
        logic [31:0] sample_time;
        logic [1:0]  counter_mode;
        logic [31:0] speed_limit;
        logic [31:0] target_id;
    } t_sample;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_row;
        logic [31:0] out_id;
        logic [63:0] delta;
        logic [31:0] rate_value;
        logic [31:0] out_time;
    } t_result;

    // one row of per-target history
    typedef struct packed {
        logic        have_prior;
        logic [31:0] last_time;
        logic [63:0] last_count;
    } t_entry;

endpackage

### design/crm_store.sv
`timescale 1ns / 1ps
// Per-row history memory: one shared read/write address, registered read.
// Depends on crm_pkg for the entry type.
module crm_store
    import crm_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_entry            i_wdata,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/crm_div.sv
`timescale 1ns / 1ps
// Restoring 64-by-32 divider, one quotient bit per cycle.
// Depends on crm_pkg for widths; returns the low 32 quotient bits.
module crm_div
    import crm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [TIME_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_run;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_num;
    logic [TIME_W-1:0]  r_rem;
    logic [TIME_W-1:0]  r_den;

    logic [TIME_W:0]    w_part;
    logic [TIME_W:0]    w_diff;

    assign w_part = {r_rem, r_num[VALUE_W-1]};
    assign w_diff = w_part - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_num <= i_dividend;
                r_rem <= '0;
                r_den <= i_divisor;
            end else if (r_run) begin
                // keep the partial remainder when the trial subtract borrows
                if (!w_diff[TIME_W]) begin
                    r_rem <= w_diff[TIME_W-1:0];
                    r_num <= {r_num[VALUE_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_part[TIME_W-1:0];
                    r_num <= {r_num[VALUE_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[TIME_W-1:0];

endmodule

### design/counter_rate_monitor_unit.sv
`timescale 1ns / 1ps
// Counter rate monitor top level: sequencer, serial row reduction and
// digit-serial subtraction. Depends on crm_pkg, crm_store and crm_div.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-----------------------------------
//  sample   | i_sample (t_sample)      | taken when start && !busy
//  result   | o_result (t_result)      | o_valid strobe, one cycle, no stall
//
// From the start cycle, a gauge goes through row reduction, history read and load
// to the limit compare; a first counter sample stops after the load, and a zero elapsed
// time after the digit subtract (and the 32-bit wrap fix); others also run the divider.
// busy drops the cycle after o_valid. After reset busy stays high while the row
// history is marked empty, one row per cycle.
// The receiver cannot stall results.
module counter_rate_monitor_unit
    import crm_pkg::*;
#(
    parameter int ROWS = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_sample i_sample,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int SW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [16:0] ROWS_C = 17'(ROWS);
    localparam int TDIG_LAST = TIME_DIGITS - 1;
    localparam int FIX_DIGIT = TIME_W / DIGIT_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_LOAD,
        S_SUB,
        S_FIX,
        S_CHK,
        S_DIV,
        S_CMP,
        S_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic [SW-1:0]          r_clr, n_clr;
    logic [DIGIT_CNT_W-1:0] r_cnt, n_cnt;
    t_sample                r_in, n_in;
    logic [ROW_W-1:0]       r_mod, n_mod;
    logic [VALUE_W-1:0]     r_a, n_a;
    logic [VALUE_W-1:0]     r_b, n_b;
    logic [TIME_W-1:0]      r_ta, n_ta;
    logic [TIME_W-1:0]      r_tb, n_tb;
    logic                   r_brw, n_brw;
    logic                   r_tbrw, n_tbrw;
    t_result                r_res, n_res;

    logic [ROW_W:0]         w_mpart;
    logic [DIGIT_W:0]       w_dsub;
    logic [DIGIT_W:0]       w_tsub;
    logic [DIGIT_W:0]       w_dadd;
    logic                   w_we;
    logic                   w_re;
    logic [SW-1:0]          w_addr;
    t_entry                 w_wdata;
    t_entry                 w_rdata;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [TIME_W-1:0]      w_quot;

    // remainder of the row index so far, MSB first
    assign w_mpart = {r_mod, r_in.row_index[3'(ROW_W - 1) - r_cnt]};

    assign w_dsub = {1'b0, r_a[DIGIT_W-1:0]} - {1'b0, r_b[DIGIT_W-1:0]}
                  - {{DIGIT_W{1'b0}}, r_brw};
    assign w_tsub = {1'b0, r_ta[DIGIT_W-1:0]} - {1'b0, r_tb[DIGIT_W-1:0]}
                  - {{DIGIT_W{1'b0}}, r_tbrw};
    assign w_dadd = {1'b0, r_a[DIGIT_W-1:0]}
                  + {{DIGIT_W{1'b0}}, (r_cnt == DIGIT_CNT_W'(FIX_DIGIT))}
                  + {{DIGIT_W{1'b0}}, r_brw};

    assign w_div_start = (r_state == S_CHK) && (r_ta != '0);

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = SW'(r_mod);
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr;
            end
            S_READ: begin
                w_re = 1'b1;
            end
            S_LOAD: begin
                w_we                 = 1'b1;
                w_wdata.have_prior   = 1'b1;
                w_wdata.last_time    = r_in.sample_time;
                w_wdata.last_count   = r_in.sample_value;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cnt   = r_cnt;
        n_in    = r_in;
        n_mod   = r_mod;
        n_a     = r_a;
        n_b     = r_b;
        n_ta    = r_ta;
        n_tb    = r_tb;
        n_brw   = r_brw;
        n_tbrw  = r_tbrw;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == SW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_in    = i_sample;
                    n_mod   = '0;
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if ({8'b0, w_mpart} >= ROWS_C) begin
                    n_mod = ROW_W'(w_mpart - ROWS_C[ROW_W:0]);
                end else begin
                    n_mod = w_mpart[ROW_W-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIGIT_CNT_W'(ROW_W - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_res.out_row    = r_in.row_index;
                n_res.out_id     = r_in.target_id;
                n_res.out_time   = r_in.sample_time;
                n_res.delta      = '0;
                n_res.rate_value = '0;
                n_cnt            = '0;
                n_brw            = 1'b0;
                n_tbrw           = 1'b0;
                n_a              = r_in.sample_value;
                n_b              = w_rdata.last_count;
                n_ta             = r_in.sample_time;
                n_tb             = w_rdata.last_time;
                if (r_in.counter_mode == MODE_GAUGE) begin
                    n_res.delta      = r_in.sample_value;
                    n_res.rate_value = r_in.sample_value[TIME_W-1:0];
                    n_state          = S_CMP;
                end else if (!w_rdata.have_prior) begin
                    n_res.status = STAT_FIRST;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_a   = {w_dsub[DIGIT_W-1:0], r_a[VALUE_W-1:DIGIT_W]};
                n_b   = {{DIGIT_W{1'b0}}, r_b[VALUE_W-1:DIGIT_W]};
                n_brw = w_dsub[DIGIT_W];
                if (r_cnt <= DIGIT_CNT_W'(TDIG_LAST)) begin
                    n_ta   = {w_tsub[DIGIT_W-1:0], r_ta[TIME_W-1:DIGIT_W]};
                    n_tb   = {{DIGIT_W{1'b0}}, r_tb[TIME_W-1:DIGIT_W]};
                    n_tbrw = w_tsub[DIGIT_W];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIGIT_CNT_W'(NUM_DIGITS - 1)) begin
                    // a final borrow means the counter wrapped
                    n_brw = 1'b0;
                    if (w_dsub[DIGIT_W] && (r_in.counter_mode != MODE_C64)) begin
                        n_state = S_FIX;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_FIX: begin
                // add 2^32 to the wrapped 32-bit counter difference
                n_a   = {w_dadd[DIGIT_W-1:0], r_a[VALUE_W-1:DIGIT_W]};
                n_brw = w_dadd[DIGIT_W];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIGIT_CNT_W'(NUM_DIGITS - 1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_res.delta = r_a;
                if (r_ta == '0) begin
                    n_res.status = STAT_ZERO;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res.rate_value = w_quot;
                    n_state          = S_CMP;
                end
            end
            S_CMP: begin
                n_res.status = (r_res.rate_value < r_in.speed_limit) ? STAT_EMIT
                                                                     : STAT_OVER;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
        end
        r_in   <= n_in;
        r_mod  <= n_mod;
        r_a    <= n_a;
        r_b    <= n_b;
        r_ta   <= n_ta;
        r_tb   <= n_tb;
        r_brw  <= n_brw;
        r_tbrw <= n_tbrw;
        r_res  <= n_res;
    end

    crm_store #(
        .DEPTH (ROWS),
        .ADDR_W(SW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_re   (w_re),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    crm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(r_a),
        .i_divisor (r_ta),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_result = r_res;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for counter_rate_monitor_unit: queued samples drive the
// command port, and an in-bench rate predictor checks every result strobe.
// Depends on crm_pkg and the design sources only.
module tb;
    import crm_pkg::*;

    localparam int ROWS = 256;
    localparam int RANDOM_SAMPLES = 1430;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_sample i_sample = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    counter_rate_monitor_unit #(
        .ROWS(ROWS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sample(i_sample),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor copy of the per-row history
    bit [63:0] hist_count [ROWS];
    bit [31:0] hist_time  [ROWS];
    bit        hist_valid [ROWS];

    // stimulus-side view of each row, used to build plausible sequences
    bit [63:0] gen_value [ROWS];
    bit [31:0] gen_time  [ROWS];
    bit [1:0]  gen_mode  [ROWS];
    bit        gen_seen  [ROWS];

    t_sample sample_queue [$];
    t_result expected_results [$];
    int      mismatch_count = 0;
    bit      taken = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;

    function automatic t_result predict_rate(t_sample s);
        t_result     r;
        int          slot;
        logic [63:0] diff;
        logic [63:0] prev;
        logic [31:0] elapsed;
        logic [31:0] rate;
        logic [1:0]  status;
        slot = int'(s.row_index) % ROWS;
        diff = '0;
        rate = '0;
        if (s.counter_mode == MODE_GAUGE) begin
            diff = s.sample_value;
            rate = s.sample_value[31:0];
            status = (rate < s.speed_limit) ? STAT_EMIT : STAT_OVER;
        end else if (!hist_valid[slot]) begin
            status = STAT_FIRST;
        end else begin
            prev = hist_count[slot];
            elapsed = s.sample_time - hist_time[slot];
            diff = s.sample_value - prev;
            // 32-bit counters wrapped past 2^32; 64-bit wrap falls out mod 2^64
            if (prev > s.sample_value && s.counter_mode != MODE_C64)
                diff = diff + 64'h1_0000_0000;
            if (elapsed == 32'd0) begin
                status = STAT_ZERO;
            end else begin
                rate = 32'(diff / {32'd0, elapsed});
                status = (rate < s.speed_limit) ? STAT_EMIT : STAT_OVER;
            end
        end
        hist_count[slot] = s.sample_value;
        hist_time[slot] = s.sample_time;
        hist_valid[slot] = 1'b1;
        r.status = status;
        r.out_row = s.row_index;
        r.out_id = s.target_id;
        r.delta = diff;
        r.rate_value = rate;
        r.out_time = s.sample_time;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected st=%0d row=%0d id=%h delta=%h rate=%h time=%h",
                     $realtime, what, want.status, want.out_row, want.out_id,
                     want.delta, want.rate_value, want.out_time);
            $display("%0t %s:   actual st=%0d row=%0d id=%h delta=%h rate=%h time=%h",
                     $realtime, what, got.status, got.out_row, got.out_id,
                     got.delta, got.rate_value, got.out_time);
        end
    endtask

    task automatic push_sample(input logic [7:0] row, input logic [63:0] value,
                               input logic [31:0] stamp, input logic [1:0] mode,
                               input logic [31:0] limit, input logic [31:0] id);
        t_sample s;
        int      slot;
        s.row_index = row;
        s.sample_value = value;
        s.sample_time = stamp;
        s.counter_mode = mode;
        s.speed_limit = limit;
        s.target_id = id;
        sample_queue.push_back(s);
        slot = int'(row) % ROWS;
        gen_value[slot] = value;
        gen_time[slot] = stamp;
        gen_mode[slot] = mode;
        gen_seen[slot] = 1'b1;
    endtask

    task automatic add_random_sample();
        logic [7:0]  row;
        logic [63:0] value;
        logic [63:0] step;
        logic [31:0] stamp;
        logic [31:0] limit;
        logic [1:0]  mode;
        int          pick;
        int          slot;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            row = 8'($urandom_range(0, 15));
        else if (pick < 90)
            row = 8'($urandom_range(0, 255));
        else
            row = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        slot = int'(row) % ROWS;
        step = {$urandom, $urandom} >> $urandom_range(0, 63);
        case ($urandom_range(0, 3))
            0: limit = $urandom;
            1: limit = $urandom_range(0, 4096);
            2: limit = '1;
            default: limit = $urandom_range(0, 64);
        endcase
        if ($urandom_range(0, 99) < 15) begin
            push_sample(8'($urandom_range(0, 255)), {$urandom, $urandom}, $urandom,
                        2'($urandom_range(0, 3)), $urandom, $urandom);
        end else begin
            mode = gen_mode[slot];
            if (!gen_seen[slot] || $urandom_range(0, 9) == 0)
                mode = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                stamp = gen_time[slot] + $urandom_range(1, 600);
            else if (pick < 87)
                stamp = gen_time[slot];
            else if (pick < 93)
                stamp = gen_time[slot] - $urandom_range(1, 1000);
            else
                stamp = $urandom;
            case (mode)
                MODE_GAUGE: value = step;
                MODE_C64: value = gen_value[slot] + step;
                default: value = {32'd0, gen_value[slot][31:0] + step[31:0]};
            endcase
            push_sample(row, value, stamp, mode, limit, $urandom);
        end
    endtask

    // driver: present queued samples in bursts, hold each until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !taken)) begin
            // hold
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (sample_queue.size() != 0) begin
            start <= 1'b1;
            i_sample <= sample_queue.pop_front();
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 15);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: check result strobes, then predict any transaction taken here
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0, o_result);
            else begin
                t_result want;
                want = expected_results.pop_front();
                if (o_result.status !== want.status || o_result.out_row !== want.out_row
                        || o_result.out_id !== want.out_id
                        || o_result.delta !== want.delta
                        || o_result.rate_value !== want.rate_value
                        || o_result.out_time !== want.out_time)
                    report_mismatch("result mismatch", want, o_result);
            end
        end
        taken = i_rst_n && start && !busy;
        if (taken)
            expected_results.push_back(predict_rate(i_sample));
    end

    initial begin
        // directed corners: gauge limits, first sample, wraps, zero and
        // backward elapsed time, spare mode, rate truncation
        push_sample(8'd0, 64'd0, 32'd0, MODE_GAUGE, 32'd0, 32'd0);
        push_sample(8'd255, '1, '1, MODE_GAUGE, '1, '1);
        push_sample(8'd1, 64'd5, 32'd7, MODE_GAUGE, 32'd6, 32'h1234);
        push_sample(8'd10, 64'd100, 32'd1000, MODE_C32, 32'd1000, 32'd1);
        push_sample(8'd10, 64'd700, 32'd1010, MODE_C32, 32'd1000, 32'd2);
        push_sample(8'd10, 64'd1300, 32'd1020, MODE_C32, 32'd60, 32'd3);
        push_sample(8'd10, 64'd50, 32'd1030, MODE_C32, '1, 32'd4);
        push_sample(8'd10, 64'd60, 32'd1030, MODE_C32, 32'd5, 32'd5);
        push_sample(8'd10, 64'd70, 32'd1000, MODE_C32, '1, 32'd6);
        push_sample(8'd11, '1, '1, MODE_C64, 32'd0, 32'd7);
        push_sample(8'd11, 64'd5, 32'd0, MODE_C64, 32'd6, 32'd8);
        push_sample(8'd11, 64'd3, 32'd2, MODE_SPARE, '1, 32'd9);
        push_sample(8'd12, 64'd0, 32'd0, MODE_C64, 32'd0, 32'd10);
        push_sample(8'd12, '1, 32'd1, MODE_C64, '1, 32'd11);
        push_sample(8'd12, 64'h1_0000_0000, 32'd3, MODE_GAUGE, 32'd1, 32'd12);
        push_sample(8'd12, 64'h3_0000_0000, 32'd5, MODE_C64, 32'd1, 32'd13);
        push_sample(8'd13, 64'hFFFF_FFFF_0000_0000, 32'd10, MODE_C32, '1, 32'd14);
        push_sample(8'd13, 64'd1, 32'd11, MODE_C32, '1, 32'd15);
        push_sample(8'd200, 64'd9, 32'd0, MODE_SPARE, 32'd0, 32'd16);
        push_sample(8'd200, 64'd9, 32'd0, MODE_C64, 32'd0, 32'd17);
        repeat (RANDOM_SAMPLES) add_random_sample();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_queue.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatch_count++;
            $display("%0d results never arrived", expected_results.size());
        end
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
design/crm_pkg.sv
design/crm_store.sv
design/crm_div.sv
design/counter_rate_monitor_unit.sv
dv/tb.sv
